// ===== rtl/core/cosine_annealing_rate_assert.svh =====
// Assertion macros for the checker of this block.
`ifndef COSINE_ANNEALING_RATE_ASSERT_SVH
`define COSINE_ANNEALING_RATE_ASSERT_SVH

// Checked only while reset is released.
`define CAR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every clock edge, reset included.
`define CAR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/core/car_pkg.sv =====
package car_pkg;

  localparam int PHASE_BITS     = 16;
  localparam int ITERATION_BITS = 32;

  localparam int RATE_W = 32;
  // iteration bits that reach the divider
  localparam int IT_W   = (ITERATION_BITS < RATE_W) ? ITERATION_BITS : RATE_W;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam int COS_W        = 31;
  localparam int ANG_W        = 31;
  localparam int ANG_SHIFT    = 30 - PHASE_BITS;

  localparam logic [31:0]      CORDIC_X0 = 32'd652032874;
  localparam logic [COS_W-1:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [31:0]      HALF_Q30  = 32'h2000_0000;

  localparam int DIV_STAGES  = IT_W + PHASE_BITS + 1;
  localparam int POST_STAGES = 5;
  localparam int LATENCY     = DIV_STAGES + CORDIC_STEPS + 1 + POST_STAGES;

  localparam logic [RATE_W-1:0] MAX_RATE_RST     = 32'd26843546;
  localparam logic [RATE_W-1:0] MIN_RATE_RST     = 32'd0;
  localparam logic [RATE_W-1:0] DECAY_PERIOD_RST = 32'd1000;

  typedef enum logic [1:0] {
    REG_MAX_RATE     = 2'd0,
    REG_MIN_RATE     = 2'd1,
    REG_DECAY_PERIOD = 2'd2
  } cfg_reg_t;

  // atan(2^-i) as a binary angle, 2^32 per turn
  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    case (idx)
      5'd0:  return 32'h2000_0000;
      5'd1:  return 32'h12E4_051E;
      5'd2:  return 32'h09FB_385B;
      5'd3:  return 32'h0511_11D4;
      5'd4:  return 32'h028B_0D43;
      5'd5:  return 32'h0145_D7E1;
      5'd6:  return 32'h00A2_F61E;
      5'd7:  return 32'h0051_7C55;
      5'd8:  return 32'h0028_BE53;
      5'd9:  return 32'h0014_5F2F;
      5'd10: return 32'h000A_2F98;
      5'd11: return 32'h0005_17CC;
      5'd12: return 32'h0002_8BE6;
      5'd13: return 32'h0001_45F3;
      5'd14: return 32'h0000_A2FA;
      5'd15: return 32'h0000_517D;
      5'd16: return 32'h0000_28BE;
      5'd17: return 32'h0000_145F;
      5'd18: return 32'h0000_0A30;
      5'd19: return 32'h0000_0518;
      5'd20: return 32'h0000_028C;
      5'd21: return 32'h0000_0146;
      5'd22: return 32'h0000_00A3;
      5'd23: return 32'h0000_0051;
      5'd24: return 32'h0000_0029;
      5'd25: return 32'h0000_0014;
      5'd26: return 32'h0000_000A;
      5'd27: return 32'h0000_0005;
      5'd28: return 32'h0000_0003;
      5'd29: return 32'h0000_0001;
      default: return 32'h0000_0000;
    endcase
  endfunction

endpackage

// ===== rtl/core/car_div.sv =====
module car_div import car_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [IT_W-1:0]       in_it,
  input  logic [RATE_W-1:0]     period,
  output logic                  out_valid,
  output logic [PHASE_BITS:0]   out_phase
);

  // modulo: one restoring step per stage, dividend bits enter MSB first
  logic                m_vld_src [IT_W];
  logic [RATE_W-1:0]   m_rem_src [IT_W];
  logic [IT_W-1:0]     m_dvd_src [IT_W];
  logic [RATE_W:0]     m_trial   [IT_W];
  logic [RATE_W:0]     m_diff    [IT_W];
  logic [RATE_W-1:0]   m_rem_nxt [IT_W];
  logic                m_vld_r   [IT_W];
  logic [RATE_W-1:0]   m_rem_r   [IT_W];
  logic [IT_W-1:0]     m_dvd_r   [IT_W];

  // phase quotient: remainder shifted by zeros, one quotient bit per stage
  logic                  p_vld_src [PHASE_BITS];
  logic [RATE_W-1:0]     p_rem_src [PHASE_BITS];
  logic [PHASE_BITS-1:0] p_q_src   [PHASE_BITS];
  logic [RATE_W:0]       p_trial   [PHASE_BITS];
  logic [RATE_W:0]       p_diff    [PHASE_BITS];
  logic [RATE_W-1:0]     p_rem_nxt [PHASE_BITS];
  logic [PHASE_BITS-1:0] p_q_nxt   [PHASE_BITS];
  logic                  p_vld_r   [PHASE_BITS];
  logic [RATE_W-1:0]     p_rem_r   [PHASE_BITS];
  logic [PHASE_BITS-1:0] p_q_r     [PHASE_BITS];

  logic [RATE_W:0]     f_sum;
  logic                f_up;
  logic                f_vld_r;
  logic [PHASE_BITS:0] f_phase_r;

  always_comb begin
    m_vld_src[0] = in_valid;
    m_rem_src[0] = '0;
    m_dvd_src[0] = in_it;
    for (int k = 1; k < IT_W; k++) begin
      m_vld_src[k] = m_vld_r[k-1];
      m_rem_src[k] = m_rem_r[k-1];
      m_dvd_src[k] = m_dvd_r[k-1];
    end
    for (int k = 0; k < IT_W; k++) begin
      m_trial[k]   = {m_rem_src[k], m_dvd_src[k][IT_W-1]};
      m_diff[k]    = m_trial[k] - {1'b0, period};
      // borrow shows in the top bit since the trial stays below twice the period
      m_rem_nxt[k] = m_diff[k][RATE_W] ? m_trial[k][RATE_W-1:0] : m_diff[k][RATE_W-1:0];
    end
  end

  always_comb begin
    p_vld_src[0] = m_vld_r[IT_W-1];
    p_rem_src[0] = m_rem_r[IT_W-1];
    p_q_src[0]   = '0;
    for (int k = 1; k < PHASE_BITS; k++) begin
      p_vld_src[k] = p_vld_r[k-1];
      p_rem_src[k] = p_rem_r[k-1];
      p_q_src[k]   = p_q_r[k-1];
    end
    for (int k = 0; k < PHASE_BITS; k++) begin
      p_trial[k]   = {p_rem_src[k], 1'b0};
      p_diff[k]    = p_trial[k] - {1'b0, period};
      p_rem_nxt[k] = p_diff[k][RATE_W] ? p_trial[k][RATE_W-1:0] : p_diff[k][RATE_W-1:0];
      p_q_nxt[k]   = {p_q_src[k][PHASE_BITS-2:0], ~p_diff[k][RATE_W]};
    end
  end

  // rounding: add half the period to the final remainder, carry one more bit
  assign f_sum = {1'b0, p_rem_r[PHASE_BITS-1]} + {2'b00, period[RATE_W-1:1]};
  assign f_up  = (f_sum >= {1'b0, period});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < IT_W; k++) begin
        m_vld_r[k] <= 1'b0;
      end
      for (int k = 0; k < PHASE_BITS; k++) begin
        p_vld_r[k] <= 1'b0;
      end
      f_vld_r <= 1'b0;
    end else begin
      for (int k = 0; k < IT_W; k++) begin
        m_vld_r[k] <= m_vld_src[k];
      end
      for (int k = 0; k < PHASE_BITS; k++) begin
        p_vld_r[k] <= p_vld_src[k];
      end
      f_vld_r <= p_vld_r[PHASE_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < IT_W; k++) begin
      m_rem_r[k] <= m_rem_nxt[k];
      m_dvd_r[k] <= {m_dvd_src[k][IT_W-2:0], 1'b0};
    end
    for (int k = 0; k < PHASE_BITS; k++) begin
      p_rem_r[k] <= p_rem_nxt[k];
      p_q_r[k]   <= p_q_nxt[k];
    end
    f_phase_r <= {1'b0, p_q_r[PHASE_BITS-1]} + (PHASE_BITS+1)'(f_up);
  end

  assign out_valid = f_vld_r;
  assign out_phase = f_phase_r;

endmodule

// ===== rtl/core/car_cordic.sv =====
module car_cordic import car_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [ANG_W-1:0] in_angle,
  output logic             out_valid,
  output logic [COS_W-1:0] out_cos
);

  logic                       vld_src [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] x_src   [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_src   [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] z_src   [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] dx      [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] dy      [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] da      [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] x_nxt   [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_nxt   [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] z_nxt   [CORDIC_STEPS];
  logic                       vld_r   [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] x_r     [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_r     [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] z_r     [CORDIC_STEPS];

  logic signed [CORDIC_W-1:0] x_last;
  logic                       cos_vld_r;
  logic [COS_W-1:0]           cos_r;

  always_comb begin
    vld_src[0] = in_valid;
    x_src[0]   = $signed({{(CORDIC_W-32){1'b0}}, CORDIC_X0});
    y_src[0]   = '0;
    z_src[0]   = $signed({{(CORDIC_W-ANG_W){1'b0}}, in_angle});
    for (int k = 1; k < CORDIC_STEPS; k++) begin
      vld_src[k] = vld_r[k-1];
      x_src[k]   = x_r[k-1];
      y_src[k]   = y_r[k-1];
      z_src[k]   = z_r[k-1];
    end
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      // arithmetic shift floors toward minus infinity
      dx[k] = y_src[k] >>> k;
      dy[k] = x_src[k] >>> k;
      da[k] = $signed({{(CORDIC_W-32){1'b0}}, atan_bam(5'(k))});
      if (!z_src[k][CORDIC_W-1]) begin
        x_nxt[k] = x_src[k] - dx[k];
        y_nxt[k] = y_src[k] + dy[k];
        z_nxt[k] = z_src[k] - da[k];
      end else begin
        x_nxt[k] = x_src[k] + dx[k];
        y_nxt[k] = y_src[k] - dy[k];
        z_nxt[k] = z_src[k] + da[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        vld_r[k] <= 1'b0;
      end
      cos_vld_r <= 1'b0;
    end else begin
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        vld_r[k] <= vld_src[k];
      end
      cos_vld_r <= vld_r[CORDIC_STEPS-1];
    end
  end

  assign x_last = x_r[CORDIC_STEPS-1];

  always_ff @(posedge clk) begin
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      x_r[k] <= x_nxt[k];
      y_r[k] <= y_nxt[k];
      z_r[k] <= z_nxt[k];
    end
    if (x_last[CORDIC_W-1]) begin
      cos_r <= '0;
    end else if (x_last > $signed({{(CORDIC_W-COS_W){1'b0}}, ONE_Q30})) begin
      cos_r <= ONE_Q30;
    end else begin
      cos_r <= x_last[COS_W-1:0];
    end
  end

  assign out_valid = cos_vld_r;
  assign out_cos   = cos_r;

endmodule

// ===== rtl/core/cosine_annealing_rate.sv =====
// Cosine-annealed learning rate, one query per clock.
//
// Query: raise start with in_iteration for one cycle; it is taken at the edge
// where start is high and busy is low. busy is high only during reset.
// Result: out_rate (unsigned Q4.28) shows for exactly one cycle with out_valid.
// Every query gives exactly one result, in query order.
// Pipeline stages: iteration bits + phase bits + 1 for the divider, 31 for the
// CORDIC, 5 for squaring, scaling and the final add.
// Throughput: one query every cycle out of reset; each divider and CORDIC step
// is a stage of its own, so the pipeline never stalls.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 max_rate, 1 min_rate,
// 2 decay_period) and cfg_data; cfg_ready is high out of reset. Unknown
// indexes are dropped. Write only while no query is in flight.
// Reset (synchronous, rst_n low) empties the pipeline and loads the register
// defaults. The receiver cannot hold results off, so nothing is buffered.
module cosine_annealing_rate import car_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [RATE_W-1:0] in_iteration,
  output logic              out_valid,
  output logic [RATE_W-1:0] out_rate,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [RATE_W-1:0] cfg_data
);

  logic [RATE_W-1:0] max_rate_r;
  logic [RATE_W-1:0] min_rate_r;
  logic [RATE_W-1:0] decay_period_r;
  logic [RATE_W-1:0] period;

  logic [RATE_W:0]   diff_up;
  logic [RATE_W-1:0] mag_r;
  logic              neg_r;

  logic              in_accept;
  logic              div_vld;
  logic [PHASE_BITS:0] div_phase;
  logic [ANG_W-1:0]  angle;
  logic              cos_vld;
  logic [COS_W-1:0]  cos_val;

  logic                    sq_vld_r;
  logic [2*COS_W-1:0]      sq_r;
  logic [2*COS_W-1:0]      sq_rnd;
  logic                    w_vld_r;
  logic [COS_W-1:0]        w_r;
  logic                    pr_vld_r;
  logic [RATE_W+COS_W-1:0] prod_r;
  logic [RATE_W+COS_W-1:0] prod_rnd;
  logic                    tm_vld_r;
  logic [RATE_W:0]         term_r;
  logic signed [RATE_W+2:0] rate_sum;
  logic                    out_valid_r;
  logic [RATE_W-1:0]       out_rate_r;

  assign busy      = !rst_n;
  assign cfg_ready = rst_n;
  assign in_accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rate_r     <= MAX_RATE_RST;
      min_rate_r     <= MIN_RATE_RST;
      decay_period_r <= DECAY_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_RATE:     max_rate_r     <= cfg_data;
        REG_MIN_RATE:     min_rate_r     <= cfg_data;
        REG_DECAY_PERIOD: decay_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // a zero period acts as one
  assign period = (decay_period_r == '0) ? RATE_W'(1) : decay_period_r;

  // |max - min| and its sign, needed only at the tail of the pipeline
  assign diff_up = {1'b0, max_rate_r} - {1'b0, min_rate_r};

  always_ff @(posedge clk) begin
    neg_r <= diff_up[RATE_W];
    mag_r <= diff_up[RATE_W] ? (min_rate_r - max_rate_r) : diff_up[RATE_W-1:0];
  end

  car_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_accept),
    .in_it     (in_iteration[IT_W-1:0]),
    .period    (period),
    .out_valid (div_vld),
    .out_phase (div_phase)
  );

  // half angle: phase scaled to a quarter turn
  assign angle = {div_phase, {ANG_SHIFT{1'b0}}};

  car_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_vld),
    .in_angle  (angle),
    .out_valid (cos_vld),
    .out_cos   (cos_val)
  );

  assign sq_rnd   = sq_r + (2*COS_W)'(HALF_Q30);
  assign prod_rnd = prod_r + (RATE_W+COS_W)'(HALF_Q30);
  assign rate_sum = neg_r ? ($signed({3'b000, min_rate_r}) - $signed({2'b00, term_r}))
                          : ($signed({3'b000, min_rate_r}) + $signed({2'b00, term_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r    <= 1'b0;
      w_vld_r     <= 1'b0;
      pr_vld_r    <= 1'b0;
      tm_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sq_vld_r    <= cos_vld;
      w_vld_r     <= sq_vld_r;
      pr_vld_r    <= w_vld_r;
      tm_vld_r    <= pr_vld_r;
      out_valid_r <= tm_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_r   <= cos_val * cos_val;
    w_r    <= sq_rnd[30 +: COS_W];
    prod_r <= mag_r * w_r;
    term_r <= prod_rnd[30 +: RATE_W+1];
    if (rate_sum[RATE_W+2]) begin
      out_rate_r <= '0;
    end else if (rate_sum[RATE_W+1:RATE_W] != 2'b00) begin
      out_rate_r <= '1;
    end else begin
      out_rate_r <= rate_sum[RATE_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_rate  = out_rate_r;

endmodule

// ===== rtl/core/car_checker.sv =====
`include "cosine_annealing_rate_assert.svh"

module car_checker import car_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic cfg_ready,
  input logic out_valid
);

  localparam int WARM_W = $clog2(LATENCY + 1);

  // cycles since reset released, saturating at the pipeline latency
  logic [WARM_W-1:0] warm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= '0;
    end else if (warm_r != WARM_W'(LATENCY)) begin
      warm_r <= warm_r + WARM_W'(1);
    end
  end

  `CAR_ASSERT_RST(a_result_per_transaction, (warm_r == WARM_W'(LATENCY)) |-> (out_valid == $past(start && !busy, LATENCY)), "result strobe does not match a transaction LATENCY cycles back")

  `CAR_ASSERT_RST(a_no_early_result, (warm_r != WARM_W'(LATENCY)) |-> !out_valid, "result strobe before the pipeline could fill after reset")

  `CAR_ASSERT_ALWAYS(a_no_result_from_reset, out_valid |-> $past(rst_n), "result strobe right after a reset cycle")

  `CAR_ASSERT_RST(a_ready_out_of_reset, cfg_ready && !busy, "port not ready out of reset")

endmodule

bind cosine_annealing_rate car_checker u_car_checker (.*);

// ===== tb/cosine_annealing_rate_tb.sv =====
`timescale 1ns / 1ps

module cosine_annealing_rate_tb;
  import car_pkg::*;

  localparam int PHASE_W = 16;
  localparam int ROT_STEPS = 30;
  localparam longint GAIN_INV_Q30 = 64'd652032874;
  localparam longint UNIT_Q30 = 64'd1 << 30;
  localparam int SETTLE_CYCLES = 120;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  // rotation angles, binary angle units (2^32 per turn)
  localparam longint ROT_ANGLE [ROT_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };

  typedef struct {
    logic [RATE_W-1:0] iteration;
    logic [RATE_W-1:0] rate;
  } rate_expect_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [RATE_W-1:0] in_iteration;
  logic              out_valid;
  logic [RATE_W-1:0] out_rate;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [RATE_W-1:0] cfg_data;

  // shadow copy of the rate registers
  logic [RATE_W-1:0] max_rate_q;
  logic [RATE_W-1:0] min_rate_q;
  logic [RATE_W-1:0] period_q;

  rate_expect_t pending_rates[$];
  rate_expect_t head_rate;
  int           sender_idle_pct;
  int           mismatches;
  int           queries_sent;
  int           rates_checked;
  int           reg_writes;

  cosine_annealing_rate i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_iteration (in_iteration),
    .out_valid    (out_valid),
    .out_rate     (out_rate),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [RATE_W-1:0] annealed_rate(input logic [RATE_W-1:0] iteration);
    longint unsigned period, rem, phase, weight, mag, term;
    longint x, y, z, dx, dy, diff, rate;
    int i;
    period = (period_q == 0) ? 64'd1 : 64'(period_q);
    rem = 64'(iteration) % period;
    phase = ((rem << PHASE_W) + (period >> 1)) / period;
    x = GAIN_INV_Q30;
    y = 0;
    z = longint'(phase << (30 - PHASE_W));
    for (i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ROT_ANGLE[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ROT_ANGLE[i];
      end
    end
    if (x < 0) x = 0;
    if (x > UNIT_Q30) x = UNIT_Q30;
    // weight = cos^2 of the half angle, Q1.30
    weight = (64'(x) * 64'(x) + (64'd1 << 29)) >> 30;
    diff = longint'(64'(max_rate_q)) - longint'(64'(min_rate_q));
    mag = (diff < 0) ? 64'(-diff) : 64'(diff);
    term = (mag * weight + (64'd1 << 29)) >> 30;
    rate = longint'(64'(min_rate_q)) + ((diff < 0) ? -longint'(term) : longint'(term));
    if (rate < 0) rate = 0;
    if (rate > longint'(64'hFFFF_FFFF)) rate = longint'(64'hFFFF_FFFF);
    return rate[RATE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [RATE_W-1:0] iteration,
                                 input logic [RATE_W-1:0] got,
                                 input logic [RATE_W-1:0] want);
    mismatches++;
    $display("%0t: %s: iteration %h rate %h expected %h", $realtime, what, iteration, got,
             want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_rates.size() == 0) begin
        report_mismatch("unexpected rate", '0, out_rate, '0);
      end else begin
        head_rate = pending_rates.pop_front();
        rates_checked++;
        if (out_rate !== head_rate.rate)
          report_mismatch("rate mismatch", head_rate.iteration, out_rate, head_rate.rate);
      end
    end
  end

  task automatic send_query(input logic [RATE_W-1:0] iteration);
    rate_expect_t e;
    @(negedge clk);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start <= 1'b1;
    in_iteration <= iteration;
    @(posedge clk);
    while (busy) @(posedge clk);
    e.iteration = iteration;
    e.rate = annealed_rate(iteration);
    pending_rates.push_back(e);
    queries_sent++;
  endtask

  // lower start and let every outstanding query come back
  task automatic drain_queries();
    @(negedge clk);
    start <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [RATE_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MAX_RATE:     max_rate_q = data;
      REG_MIN_RATE:     min_rate_q = data;
      REG_DECAY_PERIOD: period_q = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_rates(input logic [RATE_W-1:0] max_rate, input logic [RATE_W-1:0] min_rate,
                           input logic [RATE_W-1:0] period);
    drain_queries();
    write_reg(REG_MAX_RATE, max_rate);
    write_reg(REG_MIN_RATE, min_rate);
    write_reg(REG_DECAY_PERIOD, period);
  endtask

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 32'h1000_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_period();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3, 4:    return $urandom;
      5:       return $urandom_range(65, 100_000);
      default: return $urandom_range(2, 64);
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_iteration();
    logic [RATE_W-1:0] per;
    per = (period_q == 0) ? 32'd1 : period_q;
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return per * $urandom_range(0, 1000) + $urandom_range(0, 2) - 1;
      2:       return $urandom_range(0, 2 * per);
      3:       return '1 - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_defaults();
    // registers untouched since reset: max 0.1, min 0, period 1000
    send_query(32'd0);
    send_query(32'd1);
    send_query(32'd499);
    send_query(32'd500);
    send_query(32'd999);
    send_query(32'd1000);
    send_query(32'd1001);
    send_query(32'h8000_0000);
    send_query(32'hFFFF_FFFF);
  endtask

  task automatic test_period_edges();
    set_rates(32'h1234_5678, 32'h0000_1000, 32'd1);
    send_query(32'd0);
    send_query(32'hFFFF_FFFF);
    // zero period behaves as a period of one
    drain_queries();
    write_reg(REG_DECAY_PERIOD, '0);
    send_query(32'd0);
    send_query(32'd12345);
    drain_queries();
    write_reg(REG_DECAY_PERIOD, '1);
    send_query(32'd0);
    send_query(32'h7FFF_FFFF);
    send_query(32'hFFFF_FFFE);
    send_query(32'hFFFF_FFFF);
  endtask

  task automatic test_rate_extremes();
    set_rates('1, '0, 32'd4);
    send_query(32'd0);
    send_query(32'd1);
    send_query(32'd2);
    send_query(32'd3);
    // min above max: rate climbs from max toward min
    set_rates('0, '1, 32'd4);
    send_query(32'd1);
    send_query(32'd2);
  endtask

  task automatic test_unmapped_index();
    drain_queries();
    write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);
    send_query(32'd3);
  endtask

  task automatic test_random(input int idle_pct, input int settings, input int per_setting);
    int base;
    int k;
    sender_idle_pct = idle_pct;
    repeat (settings) begin
      drain_queries();
      base = $urandom_range(0, 2);
      for (k = 0; k < 3; k++) begin
        case ((base + k) % 3)
          0:       write_reg(REG_MAX_RATE, pick_rate());
          1:       write_reg(REG_MIN_RATE, pick_rate());
          default: write_reg(REG_DECAY_PERIOD, pick_period());
        endcase
      end
      repeat (per_setting) send_query(pick_iteration());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_iteration = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MAX_RATE;
    cfg_data = '0;
    max_rate_q = 32'd26843546;
    min_rate_q = 32'd0;
    period_q = 32'd1000;
    sender_idle_pct = 0;
    mismatches = 0;
    queries_sent = 0;
    rates_checked = 0;
    reg_writes = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_period_edges();
    test_rate_extremes();
    test_unmapped_index();
    test_random(30, 12, 53);
    test_random(73, 12, 53);
    test_random(0, 12, 53);

    drain_queries();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (pending_rates.size() != 0) begin
      head_rate = pending_rates.pop_front();
      report_mismatch("missing rate", head_rate.iteration, '0, head_rate.rate);
    end
    $display("Ran %0d rate queries over %0d register writes; %0d rates checked.",
             queries_sent, reg_writes, rates_checked);
    $display("Periods covered zero, one, full range and random; %0d mismatches.", mismatches);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
